### rtl/jmfe_pkg.sv
// Shared types, codes and key tables of the JSON message field extractor.
`default_nettype none

package jmfe_pkg;

	// Parse modes, one per position in the message grammar.
	typedef enum logic [3:0] {
		M_START,
		M_OBJ,
		M_KEY,
		M_KCOLON,
		M_VALWS,
		M_BODY,
		M_AFTER,
		M_HOBJ,
		M_HKEY,
		M_HCOLON,
		M_HVALWS,
		M_HOST,
		M_HOTHER,
		M_XFF,
		M_XFFREST,
		M_HAFTER
	} mode_t;

	typedef enum logic [2:0] {
		K_ROUTE_BYTE    = 3'd0,
		K_BODY_BYTE     = 3'd1,
		K_ROUTE_RESTART = 3'd2,
		K_BODY_RESTART  = 3'd3,
		K_VERDICT       = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_NO_BRACE    = 3'd1,
		ERR_NO_COLON    = 3'd2,
		ERR_HDR_NOT_OBJ = 3'd3,
		ERR_UNKNOWN_KEY = 3'd4,
		ERR_EARLY_END   = 3'd5
	} err_t;

	// Key candidate masks.
	localparam logic [3:0] C_HEADERS = 4'b0001;
	localparam logic [3:0] C_BODY    = 4'b0010;
	localparam logic [3:0] C_HOST    = 4'b0100;
	localparam logic [3:0] C_XFF     = 4'b1000;
	localparam logic [3:0] C_ALL     = 4'b1111;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [3:0] KEY_POS_MAX = 4'd15;

	// Key names, right-justified: the first character sits highest.
	localparam logic [127:0] CAND_NAME [4] = '{
		128'("headers"),
		128'("body"),
		128'("Host"),
		128'("X-Forwarded-For")
	};
	localparam logic [3:0] CAND_LEN [4] = '{4'd7, 4'd4, 4'd4, 4'd15};

	// Result of one parser step, as handed to the result register.
	typedef struct packed {
		logic  vld;
		kind_t kind;
		logic [7:0] data;
		logic  ok;
		err_t  err;
	} res_t;

	// Commands from the parser to the address accumulator.
	typedef struct packed {
		logic restart;
		logic clear;
		logic fin;
		logic chr;
	} xff_ctl_t;

	// Drops the candidates that disagree with key character c at position pos.
	function automatic logic [3:0] key_step(input logic [3:0] cand, input logic [3:0] pos,
			input logic [7:0] c);
		logic [3:0] r;
		logic [3:0] idx;
		logic [7:0] nc;
		r = cand;
		for (int i = 0; i < 4; i++) begin
			idx = CAND_LEN[i] - pos - 4'd1;
			nc = CAND_NAME[i][{idx, 3'b000} +: 8];
			if (cand[i] && ((pos >= CAND_LEN[i]) || (nc != c))) begin
				r[i] = 1'b0;
			end
		end
		return r;
	endfunction

	// Candidates that are alive and fully matched.
	function automatic logic [3:0] key_hit(input logic [3:0] cand, input logic [3:0] pos);
		logic [3:0] r;
		for (int i = 0; i < 4; i++) begin
			r[i] = cand[i] && (pos == CAND_LEN[i]);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/json_message_field_extractor.sv
// Top level of the JSON message field extractor: input register, parser and result register.
//
// Usage: the sender streams one message byte per beat on the item channel (ch, item_valid,
// item_stall). A zero byte ends a message. The block answers on the result channel
// (kind, data_byte, ok, error_code, client_addr, last, result_valid, result_stall) with
// Host value bytes (route), body bytes, a restart marker before each such value, and one
// verdict beat with last set that carries success or an error code and the client address
// taken from the first X-Forwarded-For item.
// Timing: a byte is captured in the input register at the edge that accepts it and is
// parsed at the edge that loads the result register, so its result passes the input register
// and then the result register, from which the receiver takes it. One byte
// is taken every cycle while the result side keeps up; most bytes cause no result and leave
// the result register free.
// The parse state advances only at the edge that loads the result register. When the
// receiver stalls a waiting result, the byte in the input register is held and item_stall
// stays high until the result is taken; only an empty input register can still take one
// byte while the result side is stalled.
// Reset clears the parse state, the address accumulator and both valid flags; the block is
// then waiting for the opening brace of a new message. After a verdict the remaining bytes of
// the message are consumed without results until its zero byte.
`default_nettype none

module json_message_field_extractor #(
	parameter int HEADER_VALUE_BYTES = 64,
	parameter int BODY_BYTES         = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  ch,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       kind,
	output logic [7:0]       data_byte,
	output logic             ok,
	output logic [2:0]       error_code,
	output logic [31:0]      client_addr,
	output logic             last
);
	import jmfe_pkg::*;

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       adv;
	logic       step;
	res_t       res;
	xff_ctl_t   xff;
	logic [31:0] addr;

	logic        vld_s2;
	kind_t       kind_s2;
	logic [7:0]  data_s2;
	logic        ok_s2;
	err_t        err_s2;
	logic [31:0] addr_s2;

	// The result register can take a new value when it is empty or being read this cycle.
	assign adv        = !vld_s2 || !result_stall;
	assign step       = vld_s1 && adv;
	assign item_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1 <= ch;
		end
	end

	jmfe_parser #(
		.HEADER_VALUE_BYTES(HEADER_VALUE_BYTES),
		.BODY_BYTES(BODY_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(step),
		.ch(ch_s1),
		.res(res),
		.xff(xff)
	);

	jmfe_xff u_xff (
		.clk(clk),
		.arst_n(arst_n),
		.en(step),
		.ctl(xff),
		.ch(ch_s1),
		.addr(addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 && res.vld;
		end
	end

	// Only a successful verdict reports the address.
	always_ff @(posedge clk) begin
		if (step && res.vld) begin
			kind_s2 <= res.kind;
			data_s2 <= res.data;
			ok_s2   <= res.ok;
			err_s2  <= res.err;
			addr_s2 <= res.ok ? addr : 32'd0;
		end
	end

	assign result_valid = vld_s2;
	assign kind         = kind_s2;
	assign data_byte    = data_s2;
	assign ok           = ok_s2;
	assign error_code   = err_s2;
	assign client_addr  = addr_s2;
	assign last         = (kind_s2 == K_VERDICT);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (vld_s1 && vld_s2 && result_stall))
		else $error("item channel stalled while the pipeline had room");

	a_ok_is_clean_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ok) |-> (kind_s2 == K_VERDICT && err_s2 == ERR_NONE))
		else $error("success flag on a beat that is not a clean verdict");

	a_fail_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind_s2 == K_VERDICT && !ok) |-> (err_s2 != ERR_NONE && addr_s2 == '0))
		else $error("failed verdict without an error code or with an address");

	a_markers_carry_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind_s2 != K_ROUTE_BYTE && kind_s2 != K_BODY_BYTE) |-> (data_s2 == '0))
		else $error("data byte set on a marker or verdict beat");

	a_no_advance_under_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && result_stall) |=> (vld_s2 && $stable(addr_s2) && $stable(kind_s2)))
		else $error("result register changed while the receiver stalled");

endmodule

`default_nettype wire

### rtl/jmfe_xff.sv
// Address accumulator for the first X-Forwarded-For list item.
`default_nettype none

module jmfe_xff (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire jmfe_pkg::xff_ctl_t ctl,
	input  wire logic [7:0]         ch,
	output logic [31:0]             addr
);
	import jmfe_pkg::*;

	logic [2:0]  idx_q, idx_d;
	logic [1:0]  chars_q, chars_d;
	logic [9:0]  val_q, val_d;
	logic        done_q, done_d;
	logic [31:0] addr_q, addr_d;

	logic [2:0]  b_idx;
	logic [1:0]  b_chars;
	logic [9:0]  b_val;
	logic        b_done;
	logic [31:0] b_addr;
	logic [31:0] placed;
	logic        is_digit;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

	// The current octet shifted to its place; only used while idx_q is below four.
	always_comb begin
		case (idx_q[1:0])
			2'd0:    placed = {22'd0, val_q} << 24;
			2'd1:    placed = {22'd0, val_q} << 16;
			2'd2:    placed = {22'd0, val_q} << 8;
			default: placed = {22'd0, val_q};
		endcase
	end

	always_comb begin
		idx_d   = idx_q;
		chars_d = chars_q;
		val_d   = val_q;
		done_d  = done_q;
		addr_d  = addr_q;
		b_idx   = idx_q + 3'd1;
		b_chars = chars_q;
		b_val   = val_q;
		b_done  = done_q;
		b_addr  = addr_q | placed;
		if (ctl.restart || ctl.clear) begin
			idx_d   = '0;
			chars_d = '0;
			val_d   = '0;
			done_d  = 1'b0;
			addr_d  = '0;
		end else if (idx_q[2] == 1'b0 && (ctl.fin || (ctl.chr && ch == CH_DOT))) begin
			idx_d   = b_idx;
			chars_d = '0;
			val_d   = '0;
			done_d  = 1'b0;
			addr_d  = b_addr;
		end else if (ctl.chr && idx_q[2] == 1'b0) begin
			// A fourth character closes the octet before it is looked at.
			if (chars_q == 2'd3) begin
				b_chars = '0;
				b_val   = '0;
				b_done  = 1'b0;
			end else begin
				b_idx  = idx_q;
				b_addr = addr_q;
			end
			idx_d   = b_idx;
			addr_d  = b_addr;
			chars_d = b_chars;
			val_d   = b_val;
			done_d  = b_done;
			if (b_idx[2] == 1'b0) begin
				if (!b_done && is_digit) begin
					val_d = 10'(b_val * 10'd10) + {2'b00, 8'(ch - CH_ZERO)};
				end else begin
					done_d = 1'b1;
				end
				chars_d = b_chars + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			chars_q <= '0;
			val_q   <= '0;
			done_q  <= 1'b0;
			addr_q  <= '0;
		end else if (en) begin
			idx_q   <= idx_d;
			chars_q <= chars_d;
			val_q   <= val_d;
			done_q  <= done_d;
			addr_q  <= addr_d;
		end
	end

	assign addr = addr_q;

endmodule

`default_nettype wire

### rtl/jmfe_parser.sv
// Message parser: mode, key matching and value counting for one byte per cycle while enabled.
`default_nettype none

module jmfe_parser #(
	parameter int HEADER_VALUE_BYTES = 64,
	parameter int BODY_BYTES         = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [7:0]          ch,
	output jmfe_pkg::res_t           res,
	output jmfe_pkg::xff_ctl_t       xff
);
	import jmfe_pkg::*;

	localparam int CNT_MAX = (BODY_BYTES > HEADER_VALUE_BYTES) ? BODY_BYTES : HEADER_VALUE_BYTES;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam logic [CNT_W-1:0] BODY_LIMIT = CNT_W'(BODY_BYTES - 1);
	localparam logic [CNT_W-1:0] HOST_LIMIT = CNT_W'(HEADER_VALUE_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

	mode_t            mode_q, mode_d, eff_mode;
	logic [3:0]       kpos_q, kpos_d;
	logic [3:0]       kcand_q, kcand_d;
	logic [CNT_W-1:0] vcnt_q, vcnt_d;
	logic             vsent_q, vsent_d;
	logic             body_room, host_room;
	logic [3:0]       hit;
	logic [3:0]       kpos_inc;

	assign body_room = vcnt_q < BODY_LIMIT;
	assign host_room = vcnt_q < HOST_LIMIT;
	assign hit       = key_hit(kcand_q, kpos_q);
	assign kpos_inc  = (kpos_q < KEY_POS_MAX) ? kpos_q + 4'd1 : kpos_q;

	// After a value, a byte other than the separator (or, in the headers object, a space) is handled by the object mode.
	always_comb begin
		eff_mode = mode_q;
		if (mode_q == M_AFTER && ch != CH_COMMA) begin
			eff_mode = M_OBJ;
		end else if (mode_q == M_HAFTER && ch != CH_SPACE && ch != CH_COMMA) begin
			eff_mode = M_HOBJ;
		end
	end

	always_comb begin : next_state
		mode_d  = mode_q;
		kpos_d  = kpos_q;
		kcand_d = kcand_q;
		vcnt_d  = vcnt_q;
		xff     = '0;
		if (ch == CH_NUL) begin
			mode_d      = M_START;
			kpos_d      = '0;
			kcand_d     = C_ALL;
			vcnt_d      = '0;
			xff.restart = 1'b1;
		end else if (!vsent_q) begin
			unique case (eff_mode)
				M_START: begin
					if (ch == CH_LBRACE) mode_d = M_OBJ;
				end
				M_OBJ: begin
					if (ch != CH_SPACE && ch != CH_RBRACE) begin
						kpos_d  = '0;
						kcand_d = C_HEADERS | C_BODY;
						mode_d  = M_KEY;
					end
				end
				M_KEY, M_HKEY: begin
					if (ch == CH_QUOTE) begin
						mode_d = (eff_mode == M_KEY) ? M_KCOLON : M_HCOLON;
					end else begin
						kcand_d = key_step(kcand_q, kpos_q, ch);
						kpos_d  = kpos_inc;
					end
				end
				M_KCOLON: begin
					if (ch == CH_COLON) begin
						if ((hit & C_HEADERS) != '0) begin
							kcand_d = C_HEADERS;
							mode_d  = M_VALWS;
						end else if ((hit & C_BODY) != '0) begin
							kcand_d = C_BODY;
							mode_d  = M_VALWS;
						end
					end
				end
				M_VALWS: begin
					if (ch != CH_SPACE) begin
						if (kcand_q == C_HEADERS) begin
							if (ch == CH_LBRACE) mode_d = M_HOBJ;
						end else begin
							vcnt_d = '0;
							mode_d = M_BODY;
						end
					end
				end
				M_BODY: begin
					if (ch == CH_QUOTE) begin
						mode_d = M_AFTER;
					end else if (body_room) begin
						vcnt_d = vcnt_q + CNT_ONE;
					end
				end
				M_AFTER: begin
					mode_d = M_OBJ;
				end
				M_HOBJ: begin
					if (ch == CH_RBRACE) begin
						mode_d = M_AFTER;
					end else if (ch != CH_SPACE) begin
						kpos_d  = '0;
						kcand_d = C_HOST | C_XFF;
						mode_d  = M_HKEY;
					end
				end
				M_HCOLON: begin
					if (ch == CH_COLON) begin
						if ((hit & C_HOST) != '0) kcand_d = C_HOST;
						else if ((hit & C_XFF) != '0) kcand_d = C_XFF;
						else kcand_d = '0;
						mode_d = M_HVALWS;
					end
				end
				M_HVALWS: begin
					if (ch != CH_SPACE) begin
						vcnt_d = '0;
						if (kcand_q == C_HOST) begin
							mode_d = M_HOST;
						end else if (kcand_q == C_XFF) begin
							xff.clear = 1'b1;
							mode_d    = M_XFF;
						end else begin
							mode_d = M_HOTHER;
						end
					end
				end
				M_HOST: begin
					if (ch == CH_QUOTE) begin
						mode_d = M_HAFTER;
					end else if (host_room) begin
						vcnt_d = vcnt_q + CNT_ONE;
					end
				end
				M_HOTHER, M_XFFREST: begin
					if (ch == CH_QUOTE) mode_d = M_HAFTER;
				end
				M_XFF: begin
					if (ch == CH_QUOTE) begin
						xff.fin = 1'b1;
						mode_d  = M_HAFTER;
					end else if (ch == CH_COMMA) begin
						xff.fin = 1'b1;
						mode_d  = M_XFFREST;
					end else if (host_room) begin
						vcnt_d  = vcnt_q + CNT_ONE;
						xff.chr = 1'b1;
					end
				end
				M_HAFTER: begin
					if (ch == CH_COMMA) mode_d = M_HOBJ;
				end
				default: begin
					mode_d = M_START;
				end
			endcase
		end
	end

	always_comb begin : result
		res = '0;
		if (ch == CH_NUL) begin
			if (!vsent_q) begin
				res.vld  = 1'b1;
				res.kind = K_VERDICT;
				res.err  = ERR_EARLY_END;
			end
		end else if (!vsent_q) begin
			unique case (eff_mode)
				M_START: begin
					if (ch != CH_SPACE && ch != CH_LBRACE) begin
						res.vld  = 1'b1;
						res.kind = K_VERDICT;
						res.err  = ERR_NO_BRACE;
					end
				end
				M_OBJ: begin
					if (ch == CH_RBRACE) begin
						res.vld  = 1'b1;
						res.kind = K_VERDICT;
						res.ok   = 1'b1;
					end
				end
				M_KCOLON, M_HCOLON: begin
					if (ch != CH_SPACE && ch != CH_COLON) begin
						res.vld  = 1'b1;
						res.kind = K_VERDICT;
						res.err  = ERR_NO_COLON;
					end else if (eff_mode == M_KCOLON && ch == CH_COLON
							&& (hit & (C_HEADERS | C_BODY)) == '0) begin
						res.vld  = 1'b1;
						res.kind = K_VERDICT;
						res.err  = ERR_UNKNOWN_KEY;
					end
				end
				M_VALWS: begin
					if (ch != CH_SPACE) begin
						res.vld = 1'b1;
						if (kcand_q == C_HEADERS) begin
							res.vld  = (ch != CH_LBRACE);
							res.kind = K_VERDICT;
							res.err  = ERR_HDR_NOT_OBJ;
						end else begin
							res.kind = K_BODY_RESTART;
						end
					end
				end
				M_BODY: begin
					if (ch != CH_QUOTE && body_room) begin
						res.vld  = 1'b1;
						res.kind = K_BODY_BYTE;
						res.data = ch;
					end
				end
				M_HVALWS: begin
					if (ch != CH_SPACE && kcand_q == C_HOST) begin
						res.vld  = 1'b1;
						res.kind = K_ROUTE_RESTART;
					end
				end
				M_HOST: begin
					if (ch != CH_QUOTE && host_room) begin
						res.vld  = 1'b1;
						res.kind = K_ROUTE_BYTE;
						res.data = ch;
					end
				end
				default: begin
					res = '0;
				end
			endcase
		end
	end

	// A verdict closes the message until its terminating NUL.
	assign vsent_d = (ch == CH_NUL) ? 1'b0 : (vsent_q | (res.vld && res.kind == K_VERDICT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			kpos_q  <= '0;
			kcand_q <= C_ALL;
			vcnt_q  <= '0;
			vsent_q <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			kpos_q  <= kpos_d;
			kcand_q <= kcand_d;
			vcnt_q  <= vcnt_d;
			vsent_q <= vsent_d;
		end
	end

endmodule

`default_nettype wire
